[hdl/command_retry_sequencer_unit_macros.svh]
// Assertion macros shared by the command retry sequencer RTL
`ifndef COMMAND_RETRY_SEQUENCER_UNIT_MACROS_SVH
`define COMMAND_RETRY_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crs assertion failed");

// Next-cycle implication, checked out of reset
`define CRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crs assertion failed");

`endif

[hdl/crs_pkg.sv]
// Types, codes and constants for the command retry sequencer
`default_nettype none
package crs_pkg;

  localparam int unsigned CRS_MAX_COMMANDS = 64;

  // Request codes
  localparam logic [2:0] REQ_START     = 3'd0;
  localparam logic [2:0] REQ_POLL      = 3'd1;
  localparam logic [2:0] REQ_SUBMITTED = 3'd2;
  localparam logic [2:0] REQ_DEFER     = 3'd3;
  localparam logic [2:0] REQ_COMPLETE  = 3'd4;
  localparam logic [2:0] REQ_NOTICE    = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_RETRY_DELAY  = 2'd0;
  localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd1;
  localparam logic [1:0] CFG_CMD_COUNT    = 2'd2;

  localparam logic [15:0] RETRY_DELAY_RST  = 16'd1000;
  localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd3;
  localparam logic [6:0]  CMD_COUNT_RST    = 7'd8;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_COMMAND  = 3'b010,
    PH_COMPLETE = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [6:0]  position;
    logic [7:0]  attempts;
    logic        pending;
    logic [31:0] next_time;
    logic        ready;
  } crs_state_t;

  typedef struct packed {
    logic [15:0] retry_delay;
    logic [7:0]  max_attempts;
    logic [6:0]  cmd_count;
  } crs_cfg_t;

  typedef struct packed {
    logic       command_ready;
    logic [5:0] current_command;
    logic       sequence_done;
    logic       ready_seen;
    logic       awaiting_answer;
  } crs_result_t;

endpackage
`default_nettype wire

[hdl/command_retry_sequencer_unit.sv]
// Top level of the command retry sequencer
// The result beat is registered and appears in the cycle after its event beat is accepted.
// Throughput: one event per cycle while results are taken; the state update is combinational.
// A new event enters in the cycle the waiting result is taken; a stalled result holds the input.
// Reset (rst_n low, synchronous): idle phase, counters and flags cleared,
// registers back to delay 1000 ms, 3 attempts, 8 commands.
`default_nettype none
`include "command_retry_sequencer_unit_macros.svh"
module command_retry_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_now_ms,
  input  logic        in_result_ok,
  input  logic        in_notice_is_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_command_ready,
  output logic [5:0]  out_current_command,
  output logic        out_sequence_done,
  output logic        out_ready_seen,
  output logic        out_awaiting_answer
);
  import crs_pkg::*;

  crs_cfg_t    cfg_r;
  crs_state_t  state_r;
  crs_state_t  state_nxt;
  crs_result_t result_nxt;
  crs_result_t result_r;
  logic        out_valid_r;
  logic        in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_delay  <= RETRY_DELAY_RST;
      cfg_r.max_attempts <= MAX_ATTEMPTS_RST;
      cfg_r.cmd_count    <= CMD_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RETRY_DELAY:  cfg_r.retry_delay  <= cfg_wdata;
        CFG_MAX_ATTEMPTS: cfg_r.max_attempts <= cfg_wdata[7:0];
        CFG_CMD_COUNT:    cfg_r.cmd_count    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  crs_step u_step (
    .state           (state_r),
    .cfg             (cfg_r),
    .req_type        (in_req_type),
    .now_ms          (in_now_ms),
    .result_ok       (in_result_ok),
    .notice_is_ready (in_notice_is_ready),
    .state_nxt       (state_nxt),
    .result          (result_nxt)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= PH_IDLE;
      state_r.position  <= '0;
      state_r.attempts  <= '0;
      state_r.pending   <= 1'b0;
      state_r.next_time <= '0;
      state_r.ready     <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_command_ready   = result_r.command_ready;
  assign out_current_command = result_r.current_command;
  assign out_sequence_done   = result_r.sequence_done;
  assign out_ready_seen      = result_r.ready_seen;
  assign out_awaiting_answer = result_r.awaiting_answer;

  // Checks
  `CRS_ASSERT_NXT(a_fire_gives_beat, in_fire, out_valid)
  `CRS_ASSERT_NXT(a_start_opens, in_fire && (in_req_type == REQ_START),
    out_command_ready && (out_current_command == 6'd0) && !out_awaiting_answer)
  `CRS_ASSERT_NXT(a_submit_blocks, in_fire && (in_req_type == REQ_SUBMITTED),
    out_awaiting_answer && !out_command_ready)
  `CRS_ASSERT_IMP(a_done_quiet, out_valid && out_sequence_done,
    !out_command_ready && (out_current_command == 6'd0))

endmodule
`default_nettype wire

[hdl/crs_step.sv]
// Next-state and result logic for one event beat
`default_nettype none
module crs_step (
  input  crs_pkg::crs_state_t  state,
  input  crs_pkg::crs_cfg_t    cfg,
  input  logic [2:0]           req_type,
  input  logic [31:0]          now_ms,
  input  logic                 result_ok,
  input  logic                 notice_is_ready,
  output crs_pkg::crs_state_t  state_nxt,
  output crs_pkg::crs_result_t result
);
  import crs_pkg::*;

  localparam logic [6:0] MaxCmd = 7'(CRS_MAX_COMMANDS);

  logic [6:0]  eff_count;
  logic [6:0]  pos_inc;
  logic [31:0] diff;
  logic [31:0] retry_time;
  logic        due;

  // Clamp the list length to what the unit supports
  assign eff_count  = (cfg.cmd_count > MaxCmd) ? MaxCmd : cfg.cmd_count;
  assign pos_inc    = state.position + 7'd1;
  assign diff       = now_ms - state.next_time;
  assign retry_time = now_ms + {16'd0, cfg.retry_delay};

  // Event update; due follows the sign of now minus the stored deadline unless a branch sets it
  always_comb begin
    state_nxt = state;
    due       = ~diff[31];
    case (req_type)
      REQ_START: begin
        state_nxt.phase     = PH_COMMAND;
        state_nxt.position  = '0;
        state_nxt.attempts  = '0;
        state_nxt.pending   = 1'b0;
        state_nxt.ready     = 1'b0;
        state_nxt.next_time = now_ms;
        due                 = 1'b1;
      end
      REQ_SUBMITTED: begin
        state_nxt.pending = 1'b1;
        if (state.attempts != 8'hFF) begin
          state_nxt.attempts = state.attempts + 8'd1;
        end
      end
      REQ_DEFER: begin
        if (!state.pending) begin
          state_nxt.next_time = retry_time;
          due                 = (cfg.retry_delay == 16'd0);
        end
      end
      REQ_COMPLETE: begin
        if (state.pending) begin
          state_nxt.pending = 1'b0;
          if (state.phase == PH_COMMAND) begin
            if (result_ok || (state.attempts >= cfg.max_attempts)) begin
              // advance to the next command
              state_nxt.attempts  = '0;
              state_nxt.position  = pos_inc;
              state_nxt.next_time = now_ms;
              due                 = 1'b1;
              if (pos_inc >= eff_count) begin
                state_nxt.phase = PH_COMPLETE;
              end
            end else begin
              state_nxt.next_time = retry_time;
              due                 = (cfg.retry_delay == 16'd0);
            end
          end
        end
      end
      REQ_NOTICE: begin
        if (notice_is_ready) begin
          state_nxt.ready = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result reflects the updated state
  always_comb begin
    result.command_ready   = !state_nxt.pending && (state_nxt.phase == PH_COMMAND) && due;
    result.current_command = (state_nxt.phase == PH_COMMAND) ? state_nxt.position[5:0] : 6'd0;
    result.sequence_done   = (state_nxt.phase == PH_COMPLETE);
    result.ready_seen      = state_nxt.ready;
    result.awaiting_answer = state_nxt.pending;
  end

endmodule
`default_nettype wire
